// ===== hw/rtl/sstt_pkg.sv =====
// Shared types and constants for the sound source track table.
// Used by the register block, the smoothing unit and the top level.
package sstt_pkg;

   localparam int SSTT_ENTRIES = 8;
   localparam int MAX_REPORT   = 8;

   localparam int REQ_DATA_W = 168;
   localparam int RSP_DATA_W = 208;
   localparam int CSR_ADDR_W = 4;

   localparam logic [15:0] ALPHA_ONE       = 16'h8000;
   localparam logic [15:0] ALPHA_RESET     = 16'd9830;
   localparam logic [31:0] PERSIST_RESET   = 32'd200000;
   localparam logic [14:0] TOLERANCE_RESET = 15'd1638;

   // Register indexes, byte address divided by four.
   typedef enum logic [1:0] {
      REG_SMOOTHING_WEIGHT = 2'd0,
      REG_EXPIRY_AGE       = 2'd1,
      REG_MATCH_TOLERANCE  = 2'd2,
      REG_UNUSED           = 2'd3
   } reg_index_type;

   // Field tag carried through the smoothing pipeline.
   typedef enum logic [1:0] {
      MIX_AZIMUTH   = 2'd0,
      MIX_ELEVATION = 2'd1,
      MIX_LEVEL     = 2'd2,
      MIX_DISTANCE  = 2'd3
   } mix_field_type;

   typedef struct packed {
      logic [15:0] smoothing_weight;
      logic [31:0] expiry_age;
      logic [14:0] match_tolerance;
   } cfg_type;

   // One row of the track memory.
   typedef struct packed {
      logic [31:0] source_id;
      logic [15:0] azimuth;
      logic [15:0] elevation;
      logic [15:0] level_db;
      logic [23:0] distance;
      logic [15:0] confidence;
      logic [15:0] frequency;
      logic [15:0] bandwidth;
      logic [47:0] seen_us;
   } row_type;

endpackage

// ===== hw/rtl/sstt_csr.sv =====
// Configuration registers of the sound source track table, APB-style access.
// Depends on sstt_pkg.
module sstt_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [sstt_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready,
   output sstt_pkg::cfg_type                cfg
);

   sstt_pkg::cfg_type     cfg_ff;
   sstt_pkg::reg_index_type reg_idx;
   logic                  wr_en;

   assign reg_idx    = sstt_pkg::reg_index_type'(csr_paddr[3:2]);
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.smoothing_weight <= sstt_pkg::ALPHA_RESET;
         cfg_ff.expiry_age       <= sstt_pkg::PERSIST_RESET;
         cfg_ff.match_tolerance  <= sstt_pkg::TOLERANCE_RESET;
      end else if (wr_en) begin
         unique case (reg_idx)
            sstt_pkg::REG_SMOOTHING_WEIGHT: cfg_ff.smoothing_weight <= csr_pwdata[15:0];
            sstt_pkg::REG_EXPIRY_AGE:       cfg_ff.expiry_age       <= csr_pwdata;
            sstt_pkg::REG_MATCH_TOLERANCE:  cfg_ff.match_tolerance  <= csr_pwdata[14:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         sstt_pkg::REG_SMOOTHING_WEIGHT: csr_prdata = {16'd0, cfg_ff.smoothing_weight};
         sstt_pkg::REG_EXPIRY_AGE:       csr_prdata = cfg_ff.expiry_age;
         sstt_pkg::REG_MATCH_TOLERANCE:  csr_prdata = {17'd0, cfg_ff.match_tolerance};
         default:                        csr_prdata = 32'd0;
      endcase
   end

endmodule

// ===== hw/rtl/sstt_mix.sv =====
// Two-stage smoothing unit: (a*new + (1-a)*old) rounded, on offset-binary values.
// Depends on sstt_pkg for the field tag type.
module sstt_mix (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_vld,
   input  sstt_pkg::mix_field_type in_tag,
   input  logic [15:0]             alpha,
   input  logic [23:0]             in_new,
   input  logic [23:0]             in_old,
   output logic                    out_vld,
   output sstt_pkg::mix_field_type out_tag,
   output logic [23:0]             out_val
);

   logic                    vld_ff, out_vld_ff;
   sstt_pkg::mix_field_type tag_ff, out_tag_ff;
   logic signed [41:0]      prod_ff;
   logic [23:0]             old_ff, out_val_ff;
   logic signed [24:0]      diff;
   logic signed [42:0]      sum;

   // old*2^15 + a*(new-old) equals the convex mix, so one multiplier suffices.
   assign diff = $signed({1'b0, in_new}) - $signed({1'b0, in_old});
   assign sum  = $signed({4'd0, old_ff, 15'd0}) + 43'(prod_ff) + 43'sd16384;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         vld_ff     <= in_vld;
         out_vld_ff <= vld_ff;
      end
      tag_ff     <= in_tag;
      old_ff     <= in_old;
      prod_ff    <= 42'($signed({1'b0, alpha}) * diff);
      out_tag_ff <= tag_ff;
      out_val_ff <= sum[38:15];
   end

   assign out_vld = out_vld_ff;
   assign out_tag = out_tag_ff;
   assign out_val = out_val_ff;

endmodule

// ===== hw/rtl/sound_source_track_table.sv =====
// Top level of the sound source track table: control sequencer and track memory.
// Depends on sstt_pkg, sstt_csr and sstt_mix.
//
// One detection is taken at a time. After acceptance the block reads every slot
// of the track memory once to find a matching, free, expired or oldest slot,
// and the decide state picks the slot. A matched slot then passes through the
// shared smoothing multiplier, and the write state writes the row back. The
// report start state then finds the first active entry, then each active entry
// is read and reported, up to eight results, each held until the receiver
// takes it. No new detection is accepted until the slot scan and the sequential
// report walk are done. The table needs no clearing after reset.
module sound_source_track_table #(
   parameter int ENTRIES = sstt_pkg::SSTT_ENTRIES
) (
   input  logic                             clock,
   input  logic                             reset,
   // tdata, lowest bit up: in_azimuth, in_elevation, in_level_db, in_distance,
   // in_confidence, in_frequency, in_bandwidth, in_time_us.
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [sstt_pkg::REQ_DATA_W-1:0]  req_tdata,
   // tdata, lowest bit up: slot_index, source id, out_azimuth, out_elevation,
   // out_level_db, out_distance, out_confidence, out_frequency, out_bandwidth,
   // out_time_us, zero fill.
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [sstt_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                             rsp_tlast,
   // tuser: touched_now.
   output logic                             rsp_tuser,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [sstt_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int RCNT_W = $clog2(sstt_pkg::MAX_REPORT);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN, S_SCAN_END, S_DECIDE, S_MIX, S_WRITE,
      S_REP_START, S_REP_RD, S_REP_LD, S_REP_WAIT
   } state_type;

   sstt_pkg::cfg_type cfg;

   sstt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Track memory and its read port.
   sstt_pkg::row_type mem [ENTRIES];
   sstt_pkg::row_type rd_row_ff, wr_row;
   logic [IDX_W-1:0]  rd_addr, rd_idx_ff;
   logic              rd_vld_ff, rd_en, wr_en;

   state_type         state_ff;
   logic [ENTRIES-1:0] active_ff;
   logic [31:0]       next_id_ff;
   sstt_pkg::row_type in_row_ff, cap_row_ff;
   logic [IDX_W-1:0]  scan_ff, slot_ff, match_idx_ff, free_idx_ff, old_idx_ff, rep_idx_ff;
   logic              match_ff, free_ff, fresh_ff, rep_last_ff;
   logic [47:0]       oldest_ff;
   logic [RCNT_W-1:0] rep_cnt_ff;
   logic [2:0]        mix_cnt_ff;
   logic [15:0]       mix_az_ff, mix_el_ff, mix_lv_ff;
   logic [23:0]       mix_dist_ff;

   logic              rsp_valid_ff, rsp_last_ff, rsp_touch_ff;
   logic [sstt_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   // Scan-side comparisons on the row that just came out of memory.
   logic [16:0]       az_diff, el_diff, az_abs, el_abs;
   logic [47:0]       age;
   logic              hit, expired, slot_free, older;
   logic [15:0]       alpha;

   assign az_diff = 17'($signed(rd_row_ff.azimuth) - $signed(in_row_ff.azimuth));
   assign el_diff = 17'($signed(rd_row_ff.elevation) - $signed(in_row_ff.elevation));
   assign az_abs  = az_diff[16] ? 17'(-az_diff) : az_diff;
   assign el_abs  = el_diff[16] ? 17'(-el_diff) : el_diff;
   assign age     = in_row_ff.seen_us - rd_row_ff.seen_us;
   assign hit     = active_ff[rd_idx_ff] && (az_abs < {2'd0, cfg.match_tolerance})
                    && (el_abs < {2'd0, cfg.match_tolerance});
   assign expired   = age > {16'd0, cfg.expiry_age};
   assign slot_free = !active_ff[rd_idx_ff] || expired;
   assign older     = rd_row_ff.seen_us < oldest_ff;
   assign alpha     = (cfg.smoothing_weight > sstt_pkg::ALPHA_ONE) ? sstt_pkg::ALPHA_ONE
                                                                   : cfg.smoothing_weight;

   // Next active slot above a given one, and the first active slot, for the report walk.
   logic              nxt_found, first_found;
   logic [IDX_W-1:0]  nxt_idx, first_idx;

   always_comb begin
      nxt_found   = 1'b0;
      nxt_idx     = '0;
      first_found = 1'b0;
      first_idx   = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (active_ff[i] && (IDX_W'(i) > rep_idx_ff)) begin
            nxt_found = 1'b1;
            nxt_idx   = IDX_W'(i);
         end
         if (active_ff[i]) begin
            first_found = 1'b1;
            first_idx   = IDX_W'(i);
         end
      end
   end

   // Smoothing unit feed.
   logic                    mix_in_vld, mix_out_vld;
   sstt_pkg::mix_field_type mix_in_tag, mix_out_tag;
   logic [23:0]             mix_new, mix_old, mix_out_val;

   assign mix_in_vld = (state_ff == S_MIX) && (mix_cnt_ff < 3'd4);
   assign mix_in_tag = sstt_pkg::mix_field_type'(mix_cnt_ff[1:0]);

   always_comb begin
      unique case (mix_in_tag)
         sstt_pkg::MIX_AZIMUTH: begin
            mix_new = {8'd0, ~in_row_ff.azimuth[15], in_row_ff.azimuth[14:0]};
            mix_old = {8'd0, ~cap_row_ff.azimuth[15], cap_row_ff.azimuth[14:0]};
         end
         sstt_pkg::MIX_ELEVATION: begin
            mix_new = {8'd0, ~in_row_ff.elevation[15], in_row_ff.elevation[14:0]};
            mix_old = {8'd0, ~cap_row_ff.elevation[15], cap_row_ff.elevation[14:0]};
         end
         sstt_pkg::MIX_LEVEL: begin
            mix_new = {8'd0, ~in_row_ff.level_db[15], in_row_ff.level_db[14:0]};
            mix_old = {8'd0, ~cap_row_ff.level_db[15], cap_row_ff.level_db[14:0]};
         end
         default: begin
            mix_new = in_row_ff.distance;
            mix_old = cap_row_ff.distance;
         end
      endcase
   end

   sstt_mix u_mix (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (mix_in_vld),
      .in_tag  (mix_in_tag),
      .alpha   (alpha),
      .in_new  (mix_new),
      .in_old  (mix_old),
      .out_vld (mix_out_vld),
      .out_tag (mix_out_tag),
      .out_val (mix_out_val)
   );

   // Row written back: fresh rows take the detection and a new id, matched rows the mix.
   always_comb begin
      wr_row = in_row_ff;
      if (fresh_ff) begin
         wr_row.source_id = next_id_ff;
      end else begin
         wr_row.source_id = cap_row_ff.source_id;
         wr_row.azimuth   = mix_az_ff;
         wr_row.elevation = mix_el_ff;
         wr_row.level_db  = mix_lv_ff;
         wr_row.distance  = mix_dist_ff;
      end
   end

   assign wr_en   = (state_ff == S_WRITE);
   assign rd_en   = (state_ff == S_SCAN);
   assign rd_addr = (state_ff == S_SCAN) ? scan_ff : rep_idx_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[slot_ff] <= wr_row;
      end
      rd_row_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         active_ff    <= '0;
         next_id_ff   <= 32'd1;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_vld_ff <= rd_en;
         rd_idx_ff <= scan_ff;
         if (mix_out_vld) begin
            unique case (mix_out_tag)
               sstt_pkg::MIX_AZIMUTH:   mix_az_ff <= {~mix_out_val[15], mix_out_val[14:0]};
               sstt_pkg::MIX_ELEVATION: mix_el_ff <= {~mix_out_val[15], mix_out_val[14:0]};
               sstt_pkg::MIX_LEVEL:     mix_lv_ff <= {~mix_out_val[15], mix_out_val[14:0]};
               default:                 mix_dist_ff <= mix_out_val;
            endcase
         end
         // Slot selection runs on each row as it arrives from memory.
         if (rd_vld_ff && (state_ff == S_SCAN || state_ff == S_SCAN_END)) begin
            if (hit && !match_ff) begin
               match_ff     <= 1'b1;
               match_idx_ff <= rd_idx_ff;
               cap_row_ff   <= rd_row_ff;
            end
            if (slot_free && !free_ff) begin
               free_ff     <= 1'b1;
               free_idx_ff <= rd_idx_ff;
            end
            if (older) begin
               oldest_ff  <= rd_row_ff.seen_us;
               old_idx_ff <= rd_idx_ff;
            end
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  in_row_ff.azimuth    <= req_tdata[15:0];
                  in_row_ff.elevation  <= req_tdata[31:16];
                  in_row_ff.level_db   <= req_tdata[47:32];
                  in_row_ff.distance   <= req_tdata[71:48];
                  in_row_ff.confidence <= req_tdata[87:72];
                  in_row_ff.frequency  <= req_tdata[103:88];
                  in_row_ff.bandwidth  <= req_tdata[119:104];
                  in_row_ff.seen_us    <= req_tdata[167:120];
                  in_row_ff.source_id  <= '0;
                  match_ff   <= 1'b0;
                  free_ff    <= 1'b0;
                  oldest_ff  <= '1;
                  old_idx_ff <= '0;
                  scan_ff    <= '0;
                  state_ff   <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (scan_ff == LAST_IDX) begin
                  state_ff <= S_SCAN_END;
               end else begin
                  scan_ff <= scan_ff + IDX_W'(1);
               end
            end
            S_SCAN_END: begin
               state_ff <= S_DECIDE;
            end
            S_DECIDE: begin
               fresh_ff   <= !match_ff;
               mix_cnt_ff <= '0;
               if (match_ff) begin
                  slot_ff  <= match_idx_ff;
                  state_ff <= S_MIX;
               end else begin
                  slot_ff  <= free_ff ? free_idx_ff : old_idx_ff;
                  state_ff <= S_WRITE;
               end
            end
            S_MIX: begin
               mix_cnt_ff <= mix_cnt_ff + 3'd1;
               if (mix_out_vld && mix_out_tag == sstt_pkg::MIX_DISTANCE) begin
                  state_ff <= S_WRITE;
               end
            end
            S_WRITE: begin
               active_ff[slot_ff] <= 1'b1;
               if (fresh_ff) begin
                  next_id_ff <= next_id_ff + 32'd1;
               end
               state_ff <= S_REP_START;
            end
            S_REP_START: begin
               rep_idx_ff <= first_idx;
               rep_cnt_ff <= '0;
               state_ff   <= first_found ? S_REP_RD : S_IDLE;
            end
            S_REP_RD: begin
               rep_last_ff <= !nxt_found || (rep_cnt_ff == RCNT_W'(sstt_pkg::MAX_REPORT - 1));
               state_ff    <= S_REP_LD;
            end
            S_REP_LD: begin
               rsp_valid_ff <= 1'b1;
               rsp_last_ff  <= rep_last_ff;
               rsp_touch_ff <= (rep_idx_ff == slot_ff);
               rsp_data_ff  <= {5'd0, rd_row_ff.seen_us, rd_row_ff.bandwidth,
                                rd_row_ff.frequency, rd_row_ff.confidence,
                                rd_row_ff.distance, rd_row_ff.level_db,
                                rd_row_ff.elevation, rd_row_ff.azimuth,
                                rd_row_ff.source_id, 3'(rep_idx_ff)};
               state_ff     <= S_REP_WAIT;
            end
            S_REP_WAIT: begin
               if (rsp_tready) begin
                  rsp_valid_ff <= 1'b0;
                  if (rsp_last_ff) begin
                     state_ff <= S_IDLE;
                  end else begin
                     rep_idx_ff <= nxt_idx;
                     rep_cnt_ff <= rep_cnt_ff + RCNT_W'(1);
                     state_ff   <= S_REP_RD;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_touch_ff;

endmodule

// ===== hw/rtl/sstt_checker.sv =====
// Port-level checks for the sound source track table, bound to the top level.
// Depends on sound_source_track_table.
module sstt_checker (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic rsp_tlast
);

   // No new detection is taken while a result transfer is pending.
   a_no_req_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input accepted while a result is pending");

   // After a detection is accepted, input ready is dropped while the block works on it.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input ready right after a transfer");

   // The final result of a detection is not followed by another at once.
   a_last_ends_burst: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> !rsp_tvalid)
      else $error("result shown right after the last one");

   // A stalled result stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid)
      else $error("result withdrawn before transfer");

endmodule

bind sound_source_track_table sstt_checker u_sstt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tlast  (rsp_tlast)
);
